>>> sv/vela_pkg.sv
// shared types and constants for the voxel eikonal loss accumulator
`timescale 1ns / 1ps
`default_nettype none
package vela_pkg;

  localparam int CornerW  = 16;
  localparam int SizeW    = 16;
  localparam int LevelW   = 4;
  localparam int WeightW  = 16;
  localparam int LossW    = 32;
  localparam int CountW   = 20;
  localparam int SumW     = 56;
  localparam int RadW     = 64;
  localparam int QuoW     = 56;
  localparam int StepW    = 6;
  localparam int MulW     = 26;
  localparam int CfgIdxW  = 2;

  localparam int MaxVoxelsDefault = 1048575;
  localparam int CountFieldMax    = 1048575;

  localparam logic [CfgIdxW-1:0] REG_LOSS_WEIGHT  = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_DEPTH_MARGIN = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_BASE_LEVEL   = 2'd2;

  localparam logic [StepW-1:0] ROOT_STEPS = 6'd32;
  localparam logic [StepW-1:0] NORM_STEPS = 6'd33;
  localparam logic [StepW-1:0] MEAN_STEPS = 6'd56;

  typedef enum logic [1:0] {
    OP_SQRT = 2'b01,
    OP_DIV  = 2'b10
  } unit_op_t;

  typedef struct packed {
    logic              start;
    unit_op_t          op;
    logic [RadW-1:0]   rad;
    logic [CountW-1:0] divisor;
    logic [StepW-1:0]  steps;
  } unit_cmd_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [QuoW-1:0] quo;
  } unit_sts_t;

endpackage
`default_nettype wire

>>> sv/vela_mul.sv
// registered unsigned multiplier shared by the sequencer
`timescale 1ns / 1ps
`default_nettype none
module vela_mul
  import vela_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic [MulW-1:0]      a,
  input  wire logic [MulW-1:0]      b,
  output logic      [2*MulW-1:0]    p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule
`default_nettype wire

>>> sv/vela_shsub.sv
// shared shift and subtract unit for square root and division
`timescale 1ns / 1ps
`default_nettype none
module vela_shsub
  import vela_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire unit_cmd_t cmd,
  output unit_sts_t      sts
);

  logic [RadW-1:0]   rad;
  logic [33:0]       rem;
  logic [QuoW-1:0]   q;
  logic [CountW-1:0] dv;
  logic [StepW-1:0]  cnt;
  unit_op_t          op;
  logic              busy;
  logic              done;

  logic [33:0] rem_sh;
  logic [33:0] sub;
  logic [34:0] diff;
  logic        ge;

  always_comb begin
    if (op == OP_SQRT) begin
      rem_sh = {rem[31:0], rad[RadW-1 -: 2]};
      sub    = {q[31:0], 2'b01};
    end else begin
      rem_sh = {rem[32:0], rad[RadW-1]};
      sub    = {14'd0, dv};
    end
    diff = {1'b0, rem_sh} - {1'b0, sub};
    ge   = !diff[34];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == StepW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rad <= cmd.rad;
      dv  <= cmd.divisor;
      op  <= cmd.op;
      cnt <= cmd.steps;
      rem <= '0;
      q   <= '0;
    end else if (busy) begin
      cnt <= cnt - StepW'(1);
      rad <= (op == OP_SQRT) ? {rad[RadW-3:0], 2'b00} : {rad[RadW-2:0], 1'b0};
      rem <= ge ? diff[33:0] : rem_sh;
      q   <= {q[QuoW-2:0], ge};
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;
  assign sts.quo  = q;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (rst) cmd.start |-> !busy)
    else $error("unit started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst) done |-> $past(busy))
    else $error("unit done without work");
  a_not_both: assert property (@(posedge clk) disable iff (rst) !(busy && done))
    else $error("unit busy and done together");
`endif

endmodule
`default_nettype wire

>>> sv/voxel_eikonal_loss_accumulator.sv
// top level: eikonal loss accumulator over a stream of octree voxels
//
// one voxel per input item on the s_ group; the item with s_tlast high
// closes a batch and yields one result item on the m_ group, holding the
// weighted mean loss and the number of voxels that counted.
// an item is taken only while the block is idle; a counted voxel passes
// through a 32 step square root and a 33 step division in the shared
// shift and subtract unit, plus squaring through the shared multiplier,
// before the next ready; a voxel that does not count goes back to idle
// without using either unit.
// on a last item the result follows a 56 step mean division and two
// weight products; the products are skipped when the mean saturates, and
// both when nothing counted or the weight is 0.
// the result stays on m_tdata with m_tvalid high until m_tready is seen;
// no new item is taken meanwhile, and the accumulators are cleared as the
// result is formed. configuration is written through cfg_we, cfg_index and
// cfg_data while the block is idle. synchronous reset clears registers,
// accumulators and the sequencer; s_tready is low during reset and high
// in the first cycle after it.
`timescale 1ns / 1ps
`default_nettype none
module voxel_eikonal_loss_accumulator
  import vela_pkg::*;
#(
  parameter int MAX_VOXELS = MaxVoxelsDefault
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [WeightW-1:0]  cfg_data,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  input  wire logic [151:0]        s_tdata,   // corner_0..corner_7, voxel_size, level, pad
  input  wire logic                s_tuser,   // leaf
  input  wire logic                s_tlast,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  output logic [55:0]              m_tdata    // loss, used_count, pad
);

  localparam int CapInt = (MAX_VOXELS > CountFieldMax) ? CountFieldMax : MAX_VOXELS;
  localparam logic [CountW-1:0] CNT_CAP = CountW'(CapInt);

  typedef enum logic [14:0] {
    S_IDLE = 15'b000000000000001,
    S_GRAD = 15'b000000000000010,
    S_SQX  = 15'b000000000000100,
    S_SQY  = 15'b000000000001000,
    S_SQZ  = 15'b000000000010000,
    S_SQE  = 15'b000000000100000,
    S_ROOT = 15'b000000001000000,
    S_NORM = 15'b000000010000000,
    S_ERR  = 15'b000000100000000,
    S_ACC  = 15'b000001000000000,
    S_FIN  = 15'b000010000000000,
    S_MEAN = 15'b000100000000000,
    S_WLO  = 15'b001000000000000,
    S_WHI  = 15'b010000000000000,
    S_OUT  = 15'b100000000000000
  } state_t;

  state_t state, state_next;

  logic [WeightW-1:0] loss_weight;
  logic [LevelW-1:0]  depth_margin;
  logic [LevelW-1:0]  base_level;

  logic signed [CornerW-1:0] corner [8];
  logic [SizeW-1:0]   size;
  logic               counted;
  logic               last;
  logic [17:0]        ax, ay, az;
  logic [37:0]        sq;
  logic [MulW-1:0]    mag;
  logic [47:0]        mean;
  logic [39:0]        lo;
  logic [SumW-1:0]    error_sum;
  logic [CountW-1:0]  voxel_count;
  logic [LossW-1:0]   loss;
  logic [CountW-1:0]  used_count;

  unit_cmd_t        cmd;
  unit_sts_t        sts;
  logic [MulW-1:0]  mul_a, mul_b;
  logic [2*MulW-1:0] p;

  logic               accept;
  logic [LevelW:0]    level_min;
  logic signed [18:0] dx, dy, dz;
  logic [37:0]        sq_sum;
  logic [32:0]        n;
  logic [32:0]        n_dev;
  logic [35:0]        err;
  logic [SumW:0]      sum_wide;
  logic [63:0]        total;
  logic               fin_zero;

  // weight product lands in the cycle after the high half is issued
  logic               wend;
  logic [LossW-1:0]   loss_scaled;
  logic [LossW-1:0]   loss_shown;

  vela_shsub u_shsub (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .sts (sts)
  );

  vela_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (p)
  );

  assign accept    = s_tvalid && s_tready;
  assign s_tready  = (state == S_IDLE) && !rst;
  assign m_tvalid  = (state == S_OUT);
  assign m_tdata   = {4'd0, used_count, loss_shown};
  assign level_min = {1'b0, base_level} + {1'b0, depth_margin};
  assign fin_zero  = (voxel_count == '0) || (loss_weight == '0);

  always_comb begin
    dx = (19'(corner[4]) + 19'(corner[5]) + 19'(corner[6]) + 19'(corner[7]))
       - (19'(corner[0]) + 19'(corner[1]) + 19'(corner[2]) + 19'(corner[3]));
    dy = (19'(corner[2]) + 19'(corner[3]) + 19'(corner[6]) + 19'(corner[7]))
       - (19'(corner[0]) + 19'(corner[1]) + 19'(corner[4]) + 19'(corner[5]));
    dz = (19'(corner[1]) + 19'(corner[3]) + 19'(corner[5]) + 19'(corner[7]))
       - (19'(corner[0]) + 19'(corner[2]) + 19'(corner[4]) + 19'(corner[6]));
    sq_sum   = sq + p[37:0];
    n        = sts.quo[32:0];
    n_dev    = (n >= 33'd65536) ? (n - 33'd65536) : (33'd65536 - n);
    err      = p[51:16];
    sum_wide = {1'b0, error_sum} + (SumW+1)'(err);
    total    = {p[39:0], 24'd0} + 64'(lo);
  end

  // multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SQX: begin
        mul_a = MulW'(ax);
        mul_b = MulW'(ax);
      end
      S_SQY: begin
        mul_a = MulW'(ay);
        mul_b = MulW'(ay);
      end
      S_SQZ: begin
        mul_a = MulW'(az);
        mul_b = MulW'(az);
      end
      S_ERR: begin
        mul_a = mag;
        mul_b = mag;
      end
      S_WLO: begin
        mul_a = MulW'(mean[23:0]);
        mul_b = MulW'(loss_weight);
      end
      S_WHI: begin
        mul_a = MulW'(mean[47:24]);
        mul_b = MulW'(loss_weight);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // shared unit commands
  always_comb begin
    cmd.start   = 1'b0;
    cmd.op      = OP_SQRT;
    cmd.rad     = '0;
    cmd.divisor = '0;
    cmd.steps   = ROOT_STEPS;
    case (state)
      S_SQE: begin
        cmd.start = 1'b1;
        cmd.op    = OP_SQRT;
        cmd.rad   = {2'b00, sq_sum, 24'd0};
        cmd.steps = ROOT_STEPS;
      end
      S_ROOT: begin
        cmd.start   = sts.done;
        cmd.op      = OP_DIV;
        cmd.rad     = {sts.quo[30:0], 2'b00, 31'd0};
        cmd.divisor = CountW'(size);
        cmd.steps   = NORM_STEPS;
      end
      S_FIN: begin
        cmd.start   = last && !fin_zero;
        cmd.op      = OP_DIV;
        cmd.rad     = {error_sum, 8'd0};
        cmd.divisor = voxel_count;
        cmd.steps   = MEAN_STEPS;
      end
      default: cmd.start = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) state_next = S_GRAD;
      S_GRAD: state_next = counted ? S_SQX : S_FIN;
      S_SQX:  state_next = S_SQY;
      S_SQY:  state_next = S_SQZ;
      S_SQZ:  state_next = S_SQE;
      S_SQE:  state_next = S_ROOT;
      S_ROOT: if (sts.done) state_next = S_NORM;
      S_NORM: if (sts.done) state_next = S_ERR;
      S_ERR:  state_next = S_ACC;
      S_ACC:  state_next = S_FIN;
      S_FIN: begin
        if (!last) begin
          state_next = S_IDLE;
        end else if (fin_zero) begin
          state_next = S_OUT;
        end else begin
          state_next = S_MEAN;
        end
      end
      S_MEAN: begin
        if (sts.done) begin
          state_next = (sts.quo[55:48] != '0) ? S_OUT : S_WLO;
        end
      end
      S_WLO:  state_next = S_WHI;
      S_WHI:  state_next = S_OUT;
      S_OUT:  if (m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control state, configuration and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      loss_weight  <= '0;
      depth_margin <= '0;
      base_level   <= '0;
      error_sum    <= '0;
      voxel_count  <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_LOSS_WEIGHT:  loss_weight  <= cfg_data;
          REG_DEPTH_MARGIN: depth_margin <= cfg_data[LevelW-1:0];
          REG_BASE_LEVEL:   base_level   <= cfg_data[LevelW-1:0];
          default: ;
        endcase
      end
      if (state == S_ACC) begin
        error_sum   <= sum_wide[SumW] ? {SumW{1'b1}} : sum_wide[SumW-1:0];
        voxel_count <= voxel_count + CountW'(1);
      end
      if (state_next == S_OUT && state != S_OUT) begin
        error_sum   <= '0;
        voxel_count <= '0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          for (int i = 0; i < 8; i++) begin
            corner[i] <= s_tdata[i*CornerW +: CornerW];
          end
          size    <= (s_tdata[143:128] == '0) ? SizeW'(1) : s_tdata[143:128];
          last    <= s_tlast;
          counted <= s_tuser && ({1'b0, s_tdata[147:144]} >= level_min)
                     && (voxel_count < CNT_CAP);
        end
      end
      S_GRAD: begin
        ax <= dx[18] ? 18'(-dx) : 18'(dx);
        ay <= dy[18] ? 18'(-dy) : 18'(dy);
        az <= dz[18] ? 18'(-dz) : 18'(dz);
      end
      S_SQY: sq <= p[37:0];
      S_SQZ: sq <= sq_sum;
      S_NORM: begin
        if (sts.done) begin
          mag <= (n_dev > 33'h3FFFFFF) ? {MulW{1'b1}} : n_dev[MulW-1:0];
        end
      end
      S_FIN: begin
        if (last && fin_zero) begin
          loss       <= '0;
          used_count <= voxel_count;
        end
      end
      S_MEAN: begin
        if (sts.done) begin
          mean       <= sts.quo[47:0];
          loss       <= {LossW{1'b1}};
          used_count <= voxel_count;
        end
      end
      S_WHI: lo <= p[39:0];
      default: ;
    endcase
    if (wend) begin
      loss <= loss_scaled;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wend <= 1'b0;
    end else begin
      wend <= (state == S_WHI);
    end
  end

  assign loss_scaled = (total[63:40] != '0) ? {LossW{1'b1}} : total[39:8];
  assign loss_shown  = wend ? loss_scaled : loss;

`ifndef SYNTHESIS
  a_one_side: assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("input ready while a result is shown");
  a_cleared: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (voxel_count == '0 && error_sum == '0))
    else $error("accumulators not cleared with the result");
  a_cap: assert property (@(posedge clk) disable iff (rst) voxel_count <= CNT_CAP)
    else $error("voxel count above its cap");
`endif

endmodule
`default_nettype wire

>>> dv/tb_voxel_eikonal_loss_accumulator.sv
// self-checking testbench for the voxel eikonal loss accumulator
`timescale 1ns / 1ps
module tb_voxel_eikonal_loss_accumulator;
  import vela_pkg::*;

  typedef struct packed {
    logic [7:0][CornerW-1:0] corner;
    logic [SizeW-1:0]        vsize;
    logic [LevelW-1:0]       level;
    logic                    leaf;
    logic                    last;
  } voxel_t;

  typedef struct packed {
    logic [LossW-1:0]  loss;
    logic [CountW-1:0] used;
  } batch_loss_t;

  localparam logic [CountW-1:0] CountCap =
    (MaxVoxelsDefault < CountFieldMax) ? MaxVoxelsDefault : CountFieldMax;
  localparam logic [63:0] SumFull   = 64'h00FF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MagFull   = 64'h0000_0000_03FF_FFFF;
  localparam logic [63:0] LossFull  = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] MeanLimit = 64'h0001_0000_0000_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [WeightW-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [151:0] s_tdata = '0;  // corner_0..corner_7, voxel_size, level, pad
  logic s_tuser = 1'b0;        // leaf
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [55:0] m_tdata;        // loss, used_count, pad

  voxel_eikonal_loss_accumulator dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  voxel_t pending[$];
  batch_loss_t loss_due[$];
  voxel_t in_flight;
  int unsigned src_idle = 10;
  int unsigned dst_idle = 86;
  int unsigned mismatches = 0;

  logic [WeightW-1:0] weight = '0;
  logic [3:0] min_lvl = '0;
  logic [3:0] out_lvl = '0;
  logic [63:0] err_acc = '0;
  logic [CountW-1:0] vox_cnt = '0;

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic logic [63:0] floor_root(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  function automatic logic [63:0] voxel_error(input voxel_t v);
    longint c [8];
    longint gx;
    longint gy;
    longint gz;
    logic [63:0] sq;
    logic [63:0] s;
    logic [63:0] n;
    logic [63:0] mag;
    for (int i = 0; i < 8; i++) c[i] = longint'($signed(v.corner[i]));
    gx = (c[4] + c[5] + c[6] + c[7]) - (c[0] + c[1] + c[2] + c[3]);
    gy = (c[2] + c[3] + c[6] + c[7]) - (c[0] + c[1] + c[4] + c[5]);
    gz = (c[1] + c[3] + c[5] + c[7]) - (c[0] + c[2] + c[4] + c[6]);
    sq = gx * gx + gy * gy + gz * gz;
    s = (v.vsize == '0) ? 64'd1 : {48'd0, v.vsize};
    n = (floor_root(sq << 24) * 64'd4) / s;
    mag = (n >= 64'd65536) ? n - 64'd65536 : 64'd65536 - n;
    if (mag > MagFull) mag = MagFull;
    return (mag * mag) >> 16;
  endfunction

  task automatic absorb_voxel(input voxel_t v);
    logic [63:0] err;
    logic [63:0] mean;
    logic [63:0] scaled;
    batch_loss_t res;
    if (v.leaf && int'(v.level) >= int'(min_lvl) + int'(out_lvl) && vox_cnt < CountCap) begin
      err = voxel_error(v);
      if (err > SumFull - err_acc) err_acc = SumFull;
      else err_acc = err_acc + err;
      vox_cnt = vox_cnt + 1'b1;
    end
    if (v.last) begin
      scaled = '0;
      if (vox_cnt != '0 && weight != '0) begin
        mean = err_acc / {44'd0, vox_cnt};
        if (mean >= MeanLimit) scaled = LossFull;
        else begin
          scaled = (mean * {48'd0, weight}) >> 8;
          if (scaled > LossFull) scaled = LossFull;
        end
      end
      res.loss = scaled[LossW-1:0];
      res.used = vox_cnt;
      loss_due.push_back(res);
      err_acc = '0;
      vox_cnt = '0;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) absorb_voxel(in_flight);
      if (!s_tvalid || s_tready) begin
        if (pending.size() != 0 && $urandom_range(99) >= src_idle) begin
          in_flight = pending.pop_front();
          s_tdata <= {4'd0, in_flight.level, in_flight.vsize, in_flight.corner};
          s_tuser <= in_flight.leaf;
          s_tlast <= in_flight.last;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (loss_due.size() == 0) begin
          flag_mismatch("result item with nothing expected");
        end else begin
          if (m_tdata[31:0] !== loss_due[0].loss)
            flag_mismatch($sformatf("loss got %0h want %0h", m_tdata[31:0], loss_due[0].loss));
          if (m_tdata[51:32] !== loss_due[0].used)
            flag_mismatch($sformatf("used_count got %0d want %0d",
                                    m_tdata[51:32], loss_due[0].used));
          void'(loss_due.pop_front());
        end
      end
      m_tready <= ($urandom_range(99) >= dst_idle);
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [WeightW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(input int w, input int mi, input int ol);
    write_reg(REG_LOSS_WEIGHT, w[15:0]);
    write_reg(REG_DEPTH_MARGIN, {12'd0, mi[3:0]});
    write_reg(REG_BASE_LEVEL, {12'd0, ol[3:0]});
    weight = w[15:0];
    min_lvl = mi[3:0];
    out_lvl = ol[3:0];
  endtask

  task automatic wait_quiet();
    do @(negedge clk); while (pending.size() != 0 || s_tvalid || loss_due.size() != 0);
    repeat (100) @(posedge clk);
  endtask

  function automatic voxel_t axis_voxel(input int gx, input int gy, input int gz,
                                        input int base, input int size, input int lvl,
                                        input bit leaf, input bit last);
    voxel_t v;
    int val;
    for (int i = 0; i < 8; i++) begin
      val = base + (i[2] ? gx : 0) + (i[1] ? gy : 0) + (i[0] ? gz : 0);
      v.corner[i] = val[15:0];
    end
    v.vsize = size[15:0];
    v.level = lvl[3:0];
    v.leaf = leaf;
    v.last = last;
    return v;
  endfunction

  function automatic voxel_t random_voxel(input bit closes);
    voxel_t v;
    int pick;
    int thr;
    int s;
    int span;
    int lvl;
    pick = $urandom_range(99);
    thr = int'(min_lvl) + int'(out_lvl);
    if (pick < 15) begin
      v.corner = {$urandom, $urandom, $urandom, $urandom};
      v.vsize = 16'($urandom);
      v.level = 4'($urandom);
      v.leaf = 1'($urandom);
      v.last = closes || ($urandom_range(7) == 0);
      return v;
    end
    case ($urandom_range(9))
      0: s = 0;
      1: s = $urandom_range(65535);
      2: s = $urandom_range(64, 1);
      default: s = $urandom_range(8192, 256);
    endcase
    span = (s == 0) ? 4096 : ((s > 16384) ? 16384 : s);
    lvl = (thr <= 15) ? $urandom_range(15, thr) : $urandom_range(15);
    v = axis_voxel(int'($urandom_range(2 * span)) - span, int'($urandom_range(2 * span)) - span,
                   int'($urandom_range(2 * span)) - span, int'($urandom_range(16384)) - 8192,
                   s, lvl, 1'b1, closes);
    if ($urandom_range(3) == 0) begin
      for (int i = 0; i < 8; i++)
        v.corner[i] = v.corner[i] + 16'($urandom_range(32)) - 16'd16;
    end
    // rejected voxels: not a leaf, or above the required depth
    if (pick < 30) begin
      if (thr == 0 || $urandom_range(1) == 0) v.leaf = 1'b0;
      else v.level = 4'($urandom_range(thr > 15 ? 15 : thr - 1));
    end
    return v;
  endfunction

  task automatic random_phase(input int quota);
    int sent;
    int len;
    sent = 0;
    while (sent < quota) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(30, 1) : $urandom_range(8, 1);
      for (int j = 0; j < len; j++) pending.push_back(random_voxel(j == len - 1));
      sent += len;
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    set_regs(256, 0, 0);
    pending.push_back(axis_voxel(0, 0, 0, 0, 4096, 0, 1, 1));
    pending.push_back(axis_voxel(4096, 0, 0, 0, 4096, 3, 1, 1));
    pending.push_back(axis_voxel(65535, 0, 0, -32768, 0, 15, 1, 1));
    pending.push_back(axis_voxel(0, 0, 0, 32767, 65535, 15, 1, 0));
    pending.push_back(axis_voxel(0, 0, 0, -32768, 1, 0, 1, 1));
    pending.push_back(axis_voxel(2000, -3000, 1000, 500, 4096, 9, 0, 1));
    pending.push_back(axis_voxel(0, 4096, 0, -100, 4096, 5, 1, 0));
    pending.push_back(axis_voxel(0, 0, -2048, 1234, 2048, 6, 1, 0));
    pending.push_back(axis_voxel(1500, -2500, 3000, -4000, 4096, 12, 1, 1));
    wait_quiet();

    // zero weight still reports the count
    set_regs(0, 0, 0);
    pending.push_back(axis_voxel(1000, 2000, 0, 0, 4096, 2, 1, 0));
    pending.push_back(axis_voxel(-3000, 0, 500, 7, 2048, 2, 1, 1));
    wait_quiet();

    // level filter and saturated loss
    set_regs(65535, 3, 4);
    pending.push_back(axis_voxel(65535, 65535, 0, -32768, 0, 7, 1, 0));
    pending.push_back(axis_voxel(100, 0, 0, 0, 4096, 6, 1, 0));
    pending.push_back(axis_voxel(100, 0, 0, 0, 4096, 15, 0, 0));
    pending.push_back(axis_voxel(0, 0, 0, 0, 4096, 15, 1, 1));
    wait_quiet();

    // threshold beyond any level: nothing counts
    set_regs(512, 15, 15);
    pending.push_back(axis_voxel(4096, 0, 0, 0, 4096, 15, 1, 1));
    wait_quiet();

    for (int p = 0; p < 6; p++) begin
      src_idle = (p < 2) ? 10 : ((p < 4) ? 86 : 0);
      dst_idle = (p < 2) ? 86 : ((p < 4) ? 10 : 0);
      case (p)
        0: set_regs(256, 0, 0);
        1: set_regs($urandom_range(65535), $urandom_range(2), $urandom_range(2));
        2: set_regs(65535, 0, 0);
        3: set_regs(1, 0, 15);
        4: set_regs($urandom_range(65535, 1), 15, 0);
        default: set_regs($urandom_range(65535), $urandom_range(4), $urandom_range(4));
      endcase
      random_phase(135);
      wait_quiet();
    end

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("simulation failed");
    $finish;
  end

endmodule

>>> filelist.f
sv/vela_pkg.sv
sv/vela_mul.sv
sv/vela_shsub.sv
sv/voxel_eikonal_loss_accumulator.sv
dv/tb_voxel_eikonal_loss_accumulator.sv
